// ===== hdl/kme_pkg.sv =====
// ----------------------------------------------------------------------------
// kme_pkg
// Shared sizes, item kinds, register indexes and the command and status
// structs that join the keyboard matrix controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kme_pkg;

  localparam int MAX_ROWS      = 16;
  localparam int MAX_COLS      = 8;
  localparam int KEY_CODE_BITS = 32;
  localparam int MAP_DEPTH     = MAX_ROWS * MAX_COLS;

  localparam int KIND_W       = 2;
  localparam int MAP_IDX_W    = 7;
  localparam int CODE_W       = 32;
  localparam int SEL_W        = 16;
  localparam int BITS_W       = 8;
  localparam int ROW_CNT_W    = 5;
  localparam int COL_CNT_W    = 4;
  localparam int POS_W        = $clog2(MAP_DEPTH + 1);
  localparam int ROW_IDX_W    = $clog2(MAX_ROWS);
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CODE_W-1:0] CODE_MASK =
      CODE_W'((64'd1 << KEY_CODE_BITS) - 64'd1);

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 4'd1;

  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET    = 5'd8;
  localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic search_step;
    logic scan_step;
    logic reply;
  } cmd_t;

  typedef struct packed {
    logic search_hit;
    logic search_end;
    logic scan_end;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/kme_ctrl.sv =====
// ----------------------------------------------------------------------------
// kme_ctrl
// Sequencer: accepts one item, steps the datapath through a load, a key
// search or a row scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kme_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [kme_pkg::KIND_W-1:0] kind_i,
  output logic                            in_stall_o,
  input  kme_pkg::status_t                status_i,
  output kme_pkg::cmd_t                   cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_REPLY  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (kind_i)
            kme_pkg::KIND_LOAD: state_d = ST_LOAD;
            kme_pkg::KIND_KEY:  state_d = ST_SEARCH;
            kme_pkg::KIND_SCAN: state_d = ST_SCAN;
            default:            state_d = ST_REPLY;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.mem_write = 1'b1;
        state_d = ST_REPLY;
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.search_hit || status_i.search_end) begin
          state_d = ST_REPLY;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_end) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.reply = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kme_datapath.sv =====
// ----------------------------------------------------------------------------
// kme_datapath
// Count registers, key map memory, down flags, search and scan counters,
// result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kme_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [kme_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [kme_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [kme_pkg::MAP_IDX_W-1:0]     map_index_i,
  input  wire logic [kme_pkg::CODE_W-1:0]        key_code_i,
  input  wire logic                              key_down_i,
  input  wire logic [kme_pkg::SEL_W-1:0]         scan_select_i,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic [kme_pkg::BITS_W-1:0]             column_bits_o,
  output logic                                   key_found_o,
  input  kme_pkg::cmd_t                          cmd_i,
  output kme_pkg::status_t                       status_o
);

  localparam int POS_W   = kme_pkg::POS_W;
  localparam int ROW_W   = kme_pkg::ROW_CNT_W;
  localparam int COL_W   = kme_pkg::COL_CNT_W;
  localparam int NCOL    = kme_pkg::MAX_COLS;
  localparam int NWORD   = kme_pkg::MAP_DEPTH / NCOL;
  localparam int WSEL_W  = $clog2(NWORD);
  localparam int BSEL_W  = $clog2(NCOL);

  // configuration
  logic [ROW_W-1:0] row_count_q;
  logic [COL_W-1:0] column_count_q;

  // captured item
  logic [kme_pkg::MAP_IDX_W-1:0] idx_q;
  logic [kme_pkg::CODE_W-1:0]    code_q;
  logic                          down_q;
  logic [kme_pkg::SEL_W-1:0]     sel_q;

  // sizes in use
  logic [ROW_W-1:0]       rows_use_d, rows_use_q;
  logic [COL_W-1:0]       cols_use_d, cols_use_q;
  logic [POS_W-1:0]       size_d, size_q;
  logic [ROW_W+COL_W-1:0] size_wide;

  // key search
  logic [kme_pkg::CODE_W-1:0]    key_map [kme_pkg::MAP_DEPTH];
  logic [kme_pkg::CODE_W-1:0]    rd_data_q;
  logic [POS_W-1:0]              n_issue_q;
  logic [kme_pkg::MAP_IDX_W-1:0] cmp_pos_q;
  logic                          cmp_valid_q;
  logic                          issue;
  logic                          match;

  // down flags, eight positions per word, and row scan
  logic [NWORD-1:0][NCOL-1:0]    down_words_q;
  logic [WSEL_W-1:0]             word_lo;
  logic [WSEL_W-1:0]             word_hi;
  logic [2*NCOL-1:0]             window;
  logic [ROW_W-1:0]              row_q;
  logic [POS_W-1:0]              base_q;
  logic [NCOL:0]                 col_mask_wide;
  logic [NCOL-1:0]               row_bits;
  logic                          row_live;

  // result
  logic [kme_pkg::BITS_W-1:0] res_bits_q;
  logic                       res_found_q;
  logic                       out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= kme_pkg::ROW_COUNT_RESET;
      column_count_q <= kme_pkg::COLUMN_COUNT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == kme_pkg::CFG_ROW_COUNT) begin
        row_count_q <= cfg_data_i[ROW_W-1:0];
      end
      if (cfg_index_i == kme_pkg::CFG_COLUMN_COUNT) begin
        column_count_q <= cfg_data_i[COL_W-1:0];
      end
    end
  end

  // saturate counts above the maximum
  always_comb begin
    rows_use_d = (row_count_q > ROW_W'(kme_pkg::MAX_ROWS)) ?
                 ROW_W'(kme_pkg::MAX_ROWS) : row_count_q;
    cols_use_d = (column_count_q > COL_W'(kme_pkg::MAX_COLS)) ?
                 COL_W'(kme_pkg::MAX_COLS) : column_count_q;
    size_wide  = (ROW_W+COL_W)'(rows_use_d) * (ROW_W+COL_W)'(cols_use_d);
    size_d     = size_wide[POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q      <= map_index_i;
      code_q     <= key_code_i & kme_pkg::CODE_MASK;
      down_q     <= key_down_i;
      sel_q      <= scan_select_i;
      rows_use_q <= rows_use_d;
      cols_use_q <= cols_use_d;
      size_q     <= size_d;
    end
  end

  // search: one map address issued per cycle, compared against the registered read data
  assign issue = (n_issue_q < size_q);
  assign match = cmp_valid_q &&
                 ((rd_data_q & kme_pkg::CODE_MASK) == code_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write && ({1'b0, idx_q} < POS_W'(kme_pkg::MAP_DEPTH))) begin
      key_map[idx_q] <= code_q;
    end
    rd_data_q <= key_map[n_issue_q[kme_pkg::MAP_IDX_W-1:0]];
    cmp_pos_q <= n_issue_q[kme_pkg::MAP_IDX_W-1:0];
  end

  // scan: one row per cycle; a row spans at most two flag words
  assign row_live      = (row_q < rows_use_q);
  assign word_lo       = base_q[BSEL_W +: WSEL_W];
  assign word_hi       = word_lo + 1'b1;
  assign window        = {down_words_q[word_hi], down_words_q[word_lo]} >>
                         base_q[BSEL_W-1:0];
  assign col_mask_wide = ({{NCOL{1'b0}}, 1'b1} << cols_use_q) - 1'b1;
  assign row_bits      = window[NCOL-1:0] & col_mask_wide[NCOL-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_issue_q    <= '0;
      cmp_valid_q  <= 1'b0;
      row_q        <= '0;
      base_q       <= '0;
      down_words_q <= '0;
    end else if (cmd_i.capture) begin
      n_issue_q   <= '0;
      cmp_valid_q <= 1'b0;
      row_q       <= '0;
      base_q      <= '0;
    end else begin
      if (cmd_i.search_step) begin
        cmp_valid_q <= issue;
        if (issue) begin
          n_issue_q <= n_issue_q + 1'b1;
        end
        if (match) begin
          down_words_q[cmp_pos_q[kme_pkg::MAP_IDX_W-1:BSEL_W]]
                      [cmp_pos_q[BSEL_W-1:0]] <= down_q;
        end
      end
      if (cmd_i.scan_step && row_live) begin
        row_q  <= row_q + 1'b1;
        base_q <= base_q + POS_W'(cols_use_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_bits_q  <= '0;
      res_found_q <= 1'b0;
    end else begin
      if (cmd_i.search_step && match) begin
        res_found_q <= 1'b1;
      end
      if (cmd_i.scan_step && row_live && sel_q[row_q[kme_pkg::ROW_IDX_W-1:0]]) begin
        res_bits_q <= res_bits_q | kme_pkg::BITS_W'(row_bits);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.reply) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      column_bits_o <= res_bits_q;
      key_found_o   <= res_found_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.search_hit = match;
    status_o.search_end = !issue && !cmp_valid_q;
    status_o.scan_end   = !row_live;
    status_o.out_busy   = out_valid_q && out_stall_i;
  end

endmodule

`default_nettype wire

// ===== hdl/keyboard_matrix_emulator.sv =====
// ----------------------------------------------------------------------------
// keyboard_matrix_emulator
// Row-by-column key matrix: loads host key codes into a map, sets or clears
// down flags on key events, and answers row scans with the column bits.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    kind, map_index, key_code,
//                                                  key_down, scan_select
//   out      output     out_valid_o / out_stall_i  column_bits, key_found
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index, cfg_data
//
// One item at a time. A load writes one map entry, a scan steps through the
// rows in use and a key event searches the positions in use: the search reads
// one map entry per cycle from the key map. Reset clears all down flags and
// sets both counts to 8; map entries are undefined until loaded. A result
// stalled at the output holds the block in its reply step; the next item is
// taken once it has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_matrix_emulator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [kme_pkg::KIND_W-1:0]        kind_i,
  input  wire logic [kme_pkg::MAP_IDX_W-1:0]     map_index_i,
  input  wire logic [kme_pkg::CODE_W-1:0]        key_code_i,
  input  wire logic                              key_down_i,
  input  wire logic [kme_pkg::SEL_W-1:0]         scan_select_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [kme_pkg::BITS_W-1:0]             column_bits_o,
  output logic                                   key_found_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [kme_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [kme_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  kme_pkg::cmd_t    cmd;
  kme_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  kme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kme_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .map_index_i   (map_index_i),
    .key_code_i    (key_code_i),
    .key_down_i    (key_down_i),
    .scan_select_i (scan_select_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .column_bits_o (column_bits_o),
    .key_found_o   (key_found_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

`default_nettype wire

// ===== bench/kme_checker.sv =====
// ----------------------------------------------------------------------------
// kme_checker
// Watches the item, result and register channels of the keyboard matrix
// emulator, keeps its own key map, down flags and counts, and checks every
// result transfer against the oldest predicted answer.
// ----------------------------------------------------------------------------
module kme_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_i,
  input  wire logic [kme_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [kme_pkg::MAP_IDX_W-1:0]   map_index_i,
  input  wire logic [kme_pkg::CODE_W-1:0]      key_code_i,
  input  wire logic                            key_down_i,
  input  wire logic [kme_pkg::SEL_W-1:0]       scan_select_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_stall_i,
  input  wire logic [kme_pkg::BITS_W-1:0]      column_bits_i,
  input  wire logic                            key_found_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_i,
  input  wire logic [kme_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [kme_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [kme_pkg::BITS_W-1:0] column_bits;
    logic                       key_found;
  } answer_t;

  logic [kme_pkg::CODE_W-1:0]    key_map [kme_pkg::MAP_DEPTH];
  logic                          down_flag [kme_pkg::MAP_DEPTH];
  logic [kme_pkg::ROW_CNT_W-1:0] row_count;
  logic [kme_pkg::COL_CNT_W-1:0] column_count;
  answer_t                       answers_due [$];
  int unsigned                   mismatches;

  function automatic void log_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  // Apply one item to the matrix state and return the answer it produces.
  function automatic answer_t matrix_answer(
      input logic [kme_pkg::KIND_W-1:0]    kind,
      input logic [kme_pkg::MAP_IDX_W-1:0] idx,
      input logic [kme_pkg::CODE_W-1:0]    code,
      input logic                          down,
      input logic [kme_pkg::SEL_W-1:0]     sel);
    answer_t ans;
    int      rows;
    int      cols;
    logic    hit;
    ans  = '0;
    hit  = 1'b0;
    rows = (row_count > kme_pkg::MAX_ROWS) ? kme_pkg::MAX_ROWS : int'(row_count);
    cols = (column_count > kme_pkg::MAX_COLS) ? kme_pkg::MAX_COLS : int'(column_count);
    if (kind == kme_pkg::KIND_LOAD) begin
      key_map[idx] = code & kme_pkg::CODE_MASK;
    end else if (kind == kme_pkg::KIND_KEY) begin
      // first match in position order wins
      for (int n = 0; n < rows * cols; n++) begin
        if (!hit && (key_map[n] & kme_pkg::CODE_MASK) == (code & kme_pkg::CODE_MASK)) begin
          down_flag[n] = down;
          hit          = 1'b1;
        end
      end
      ans.key_found = hit;
    end else if (kind == kme_pkg::KIND_SCAN) begin
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          if (sel[r] && down_flag[r * cols + c]) begin
            ans.column_bits[c] = 1'b1;
          end
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      row_count    = kme_pkg::ROW_COUNT_RESET;
      column_count = kme_pkg::COLUMN_COUNT_RESET;
      for (int p = 0; p < kme_pkg::MAP_DEPTH; p++) begin
        down_flag[p] = 1'b0;
      end
      answers_due.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // retire the result first: it can only belong to an older item
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          log_failure($sformatf("unexpected result column_bits %02h key_found %0b",
                                column_bits_i, key_found_i));
        end else begin
          want = answers_due.pop_front();
          if (column_bits_i !== want.column_bits || key_found_i !== want.key_found) begin
            log_failure($sformatf(
                "mismatch: column_bits expected %02h got %02h, key_found expected %0b got %0b",
                want.column_bits, column_bits_i, want.key_found, key_found_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == kme_pkg::CFG_ROW_COUNT) begin
          row_count = cfg_data_i[kme_pkg::ROW_CNT_W-1:0];
        end else if (cfg_index_i == kme_pkg::CFG_COLUMN_COUNT) begin
          column_count = cfg_data_i[kme_pkg::COL_CNT_W-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        answers_due.push_back(matrix_answer(kind_i, map_index_i, key_code_i,
                                            key_down_i, scan_select_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= answers_due.size();
    end
  end

endmodule

// ===== bench/tb_keyboard_matrix_emulator.sv =====
// ----------------------------------------------------------------------------
// tb_keyboard_matrix_emulator
// Drives loads, key events, scans and unknown items into the keyboard matrix
// emulator over a series of matrix sizes and idling mixes, with a checker
// beside the block predicting every answer.
// ----------------------------------------------------------------------------
module tb_keyboard_matrix_emulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kme_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 2 * (kme_pkg::MAP_DEPTH + 4);
  localparam int PHASE_ITEMS   = 165;
  localparam int PHASE_COUNT   = 8;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [kme_pkg::KIND_W-1:0]      kind = '0;
  logic [kme_pkg::MAP_IDX_W-1:0]   map_index = '0;
  logic [kme_pkg::CODE_W-1:0]      key_code = '0;
  logic                            key_down = 1'b0;
  logic [kme_pkg::SEL_W-1:0]       scan_select = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [kme_pkg::BITS_W-1:0]      column_bits;
  logic                            key_found;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [kme_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [kme_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  int unsigned                     fail_count;
  int unsigned                     pending;

  int                              gap_pct = 0;
  int                              stall_pct = 0;
  int                              quiet_cycles = 0;
  int                              rows_use = 8;
  int                              cols_use = 8;
  bit                              loaded [kme_pkg::MAP_DEPTH];
  bit [kme_pkg::CODE_W-1:0]        map_shadow [kme_pkg::MAP_DEPTH];
  logic                            moved;

  keyboard_matrix_emulator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .map_index_i   (map_index),
    .key_code_i    (key_code),
    .key_down_i    (key_down),
    .scan_select_i (scan_select),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .column_bits_o (column_bits),
    .key_found_o   (key_found),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  kme_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .kind_i        (kind),
    .map_index_i   (map_index),
    .key_code_i    (key_code),
    .key_down_i    (key_down),
    .scan_select_i (scan_select),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .column_bits_i (column_bits),
    .key_found_i   (key_found),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  assign moved = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready);

  // Abort when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [kme_pkg::KIND_W-1:0]    k,
                           input logic [kme_pkg::MAP_IDX_W-1:0] idx,
                           input logic [kme_pkg::CODE_W-1:0]    code,
                           input logic                          down,
                           input logic [kme_pkg::SEL_W-1:0]     sel);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    map_index   <= idx;
    key_code    <= code;
    key_down    <= down;
    scan_select <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == kme_pkg::KIND_LOAD) begin
      loaded[idx]     = 1'b1;
      map_shadow[idx] = code;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both counts back to back while the block is idle.
  task automatic set_matrix_size(input logic [kme_pkg::CFG_DATA_W-1:0] rows_val,
                                 input logic [kme_pkg::CFG_DATA_W-1:0] cols_val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= kme_pkg::CFG_ROW_COUNT;
    cfg_data  <= rows_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= kme_pkg::CFG_COLUMN_COUNT;
    cfg_data  <= cols_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rows_use = (rows_val[kme_pkg::ROW_CNT_W-1:0] > kme_pkg::MAX_ROWS) ?
               kme_pkg::MAX_ROWS : int'(rows_val[kme_pkg::ROW_CNT_W-1:0]);
    cols_use = (cols_val[kme_pkg::COL_CNT_W-1:0] > kme_pkg::MAX_COLS) ?
               kme_pkg::MAX_COLS : int'(cols_val[kme_pkg::COL_CNT_W-1:0]);
  endtask

  // Key events must never search a position that was never loaded.
  task automatic fill_map_in_use();
    for (int p = 0; p < rows_use * cols_use; p++) begin
      if (!loaded[p]) begin
        send_item(kme_pkg::KIND_LOAD, kme_pkg::MAP_IDX_W'(p), $urandom, 1'($urandom),
                  kme_pkg::SEL_W'($urandom));
      end
    end
  endtask

  task automatic send_random_item();
    int                          pick;
    int                          size;
    logic [kme_pkg::CODE_W-1:0]  code;
    logic [kme_pkg::SEL_W-1:0]   sel;
    size = rows_use * cols_use;
    pick = $urandom_range(99);
    code = $urandom;
    if (pick < 15) begin
      case ($urandom_range(3))
        0:       code = $urandom_range(7);
        1:       code = map_shadow[$urandom_range(kme_pkg::MAP_DEPTH - 1)];
        2:       code = $urandom_range(1) ? '1 : '0;
        default: ;
      endcase
      send_item(kme_pkg::KIND_LOAD, kme_pkg::MAP_IDX_W'($urandom), code, 1'($urandom),
                kme_pkg::SEL_W'($urandom));
    end else if (pick < 55) begin
      // mostly codes present in the searched part of the map
      if (size > 0 && $urandom_range(99) < 70) begin
        code = map_shadow[$urandom_range(size - 1)];
      end else if ($urandom_range(1)) begin
        code = map_shadow[$urandom_range(kme_pkg::MAP_DEPTH - 1)];
      end
      send_item(kme_pkg::KIND_KEY, kme_pkg::MAP_IDX_W'($urandom), code, 1'($urandom),
                kme_pkg::SEL_W'($urandom));
    end else if (pick < 93) begin
      sel = kme_pkg::SEL_W'($urandom);
      if ($urandom_range(3) == 0) begin
        sel = kme_pkg::SEL_W'(1) << $urandom_range(kme_pkg::SEL_W - 1);
      end
      send_item(kme_pkg::KIND_SCAN, kme_pkg::MAP_IDX_W'($urandom), $urandom, 1'($urandom),
                sel);
    end else begin
      send_item(KIND_UNUSED, kme_pkg::MAP_IDX_W'($urandom), $urandom, 1'($urandom),
                kme_pkg::SEL_W'($urandom));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2 rows of 3 columns: positions 0..5 in use
    set_matrix_size(8'd2, 8'd3);
    send_item(kme_pkg::KIND_LOAD, 7'd0,   32'h0000_0000, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_LOAD, 7'd1,   32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_item(kme_pkg::KIND_LOAD, 7'd2,   32'h0000_0041, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_LOAD, 7'd3,   32'h0000_0041, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_LOAD, 7'd4,   32'hA5A5_5A5A, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_LOAD, 7'd5,   32'h0000_1234, 1'b0, 16'h0000);
    // stored past the positions in use, so never found
    send_item(kme_pkg::KIND_LOAD, 7'd127, 32'hDEAD_BEEF, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'hDEAD_BEEF, 1'b1, 16'h0000);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'h0000_0000, 1'b1, 16'h0000);
    send_item(kme_pkg::KIND_KEY,  7'd127, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'h0000_0041, 1'b1, 16'h0000);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'h0000_0077, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'hFFFF);
    send_item(kme_pkg::KIND_SCAN, 7'd127, 32'hFFFF_FFFF, 1'b1, 16'h0000);
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'h0002);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'hA5A5_5A5A, 1'b1, 16'h0000);
    // rows at or above the row count are not selectable
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'hFFFC);
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'h0002);
    send_item(KIND_UNUSED,        7'd127, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'h0000_0000, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'hFFFF);

    // zero counts: nothing searched, nothing scanned
    set_matrix_size(8'd0, 8'd3);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'h0000_0041, 1'b1, 16'h0000);
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'hFFFF);
    set_matrix_size(8'd2, 8'd0);
    send_item(kme_pkg::KIND_KEY,  7'd0,   32'hA5A5_5A5A, 1'b0, 16'h0000);
    send_item(kme_pkg::KIND_SCAN, 7'd0,   32'h0000_0000, 1'b0, 16'hFFFF);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  set_matrix_size(8'd31, 8'd15); end
        1: begin gap_pct = 72; stall_pct = 0;  set_matrix_size(8'd16, 8'd8);  end
        2: begin gap_pct = 0;  stall_pct = 72; set_matrix_size(8'd1,  8'd1);  end
        3: begin gap_pct = 13; stall_pct = 13; set_matrix_size(8'd5,  8'd3);  end
        4: begin gap_pct = 0;  stall_pct = 0;  set_matrix_size(8'd0,  8'd8);  end
        5: begin gap_pct = 72; stall_pct = 0;  set_matrix_size(8'd16, 8'd0);  end
        6: begin
          gap_pct   = 0;
          stall_pct = 72;
          set_matrix_size(8'($urandom_range(1, kme_pkg::MAX_ROWS)),
                          8'($urandom_range(1, kme_pkg::MAX_COLS)));
        end
        default: begin
          gap_pct   = 13;
          stall_pct = 13;
          set_matrix_size(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      endcase
      fill_map_in_use();
      repeat (PHASE_ITEMS) send_random_item();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
